[design/bpdac_pkg.sv]
// Package for the byte-pair to dual-DAC serial frame block.
// Holds the channel mode codes, register indexes and command word constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bpdac_pkg;

  typedef enum logic [1:0] {
    MODE_NONE = 2'd0,
    MODE_A    = 2'd1,
    MODE_B    = 2'd2,
    MODE_BOTH = 2'd3
  } chan_mode_e;

  typedef enum logic {
    REG_CHANNEL_MODE = 1'b0,
    REG_FAST_MODE    = 1'b1
  } reg_idx_e;

  localparam logic [15:0] CmdChanA   = 16'h8000;
  localparam logic [15:0] CmdBuffer  = 16'h1000;
  localparam logic [15:0] CmdFast    = 16'h4000;
  localparam logic [15:0] DataMask   = 16'h0FFF;
  localparam logic [7:0]  MarkerByte = 8'hFF;

  localparam int unsigned WordBits  = 16;
  localparam int unsigned FrameBits = 2 * WordBits;
  localparam int unsigned CntBits   = $clog2(FrameBits);

  localparam logic [CntBits-1:0] LastOneWord = CntBits'(WordBits - 1);
  localparam logic [CntBits-1:0] LastTwoWord = CntBits'(FrameBits - 1);

endpackage

`default_nettype wire

[design/byte_pair_to_dual_dac_serial_frames_top.sv]
// Top level of the byte-pair to dual-DAC serial frame block.
// Depends on bpdac_pkg for mode codes, register indexes and word constants.
//
// Usage: bytes arrive on the input channel (in_valid_i, in_stall_o, rx_byte_i).
// Each byte updates one of the two stored data slots; a marker byte in the first slot
// redirects the next byte to the second slot. Depending on channel_mode none, one or
// two 16-bit command words are sent, one serial bit per output transfer, on the
// output channel (out_valid_o, out_stall_i, serial_bit_o, word_end_o, last_o).
// A byte's frame is registered in the holding register and then loaded into the
// shift register, from which its first bit is offered once the serialiser is free.
// The serialiser emits one bit per cycle while the receiver does not stall, so a
// byte sends 16 bits with one channel and 32 with both; a byte that sends nothing
// builds no frame.
// A built frame waits in a holding register, so the next byte is accepted
// while the current frame is still shifting out.
// Reset clears the stored bytes, the slot index and all valid flags, and
// loads channel_mode with 3 and fast_mode with 0.
// When the receiver stalls the current bit holds; once the holding register
// is full the input channel stalls too.
// Registers: channel_mode at byte address 0, fast_mode at byte address 4.
`timescale 1ns / 1ps
`default_nettype none

module byte_pair_to_dual_dac_serial_frames_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  rx_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             serial_bit_o,
  output logic             word_end_o,
  output logic             last_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  import bpdac_pkg::*;

  chan_mode_e mode_q;
  logic       fast_q;

  logic       slot_q, slot_d;
  logic [7:0] first_q, first_d;
  logic [7:0] second_q, second_d;

  logic                 pend_valid_q, pend_valid_d;
  logic [FrameBits-1:0] pend_frame_q, pend_frame_d;
  logic                 pend_two_q, pend_two_d;

  logic                 sh_valid_q, sh_valid_d;
  logic [FrameBits-1:0] sh_q, sh_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic [CntBits-1:0]   total_q, total_d;

  logic        in_acc, out_acc, sh_done, pend_move, cfg_wr;
  logic [15:0] word_a, word_b;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_BOTH;
      fast_q <= 1'b0;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[2]))
        REG_CHANNEL_MODE: mode_q <= chan_mode_e'(pwdata[1:0]);
        REG_FAST_MODE:    fast_q <= pwdata[0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[2]))
      REG_CHANNEL_MODE: prdata = {30'd0, mode_q};
      REG_FAST_MODE:    prdata = {31'd0, fast_q};
    endcase
  end

  assign out_valid_o  = sh_valid_q;
  assign serial_bit_o = sh_q[FrameBits-1];
  assign word_end_o   = (cnt_q[CntBits-2:0] == LastOneWord[CntBits-2:0]);
  assign last_o       = (cnt_q == total_q);

  assign out_acc    = sh_valid_q && !out_stall_i;
  assign sh_done    = !sh_valid_q || (out_acc && last_o);
  assign pend_move  = pend_valid_q && sh_done;
  assign in_stall_o = pend_valid_q && !pend_move;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_comb begin
    first_d  = first_q;
    second_d = second_q;
    if (slot_q) begin
      second_d = rx_byte_i;
    end else begin
      first_d = rx_byte_i;
    end
    slot_d = 1'b0;
    if (first_d == MarkerByte) begin
      slot_d  = 1'b1;
      first_d = 8'd0;
    end
    word_a = CmdChanA | (fast_q ? CmdFast : 16'd0) | (DataMask & {8'd0, first_d});
    word_b = (fast_q ? CmdFast : 16'd0) | (DataMask & {8'd0, second_d});
  end

  always_comb begin
    pend_valid_d = pend_valid_q && !pend_move;
    pend_frame_d = pend_frame_q;
    pend_two_d   = pend_two_q;
    if (in_acc) begin
      unique case (mode_q)
        MODE_A: begin
          pend_valid_d = 1'b1;
          pend_frame_d = {word_a, 16'd0};
          pend_two_d   = 1'b0;
        end
        MODE_B: begin
          pend_valid_d = 1'b1;
          pend_frame_d = {word_b, 16'd0};
          pend_two_d   = 1'b0;
        end
        MODE_BOTH: begin
          pend_valid_d = 1'b1;
          pend_frame_d = {word_b | CmdBuffer, word_a};
          pend_two_d   = 1'b1;
        end
        MODE_NONE: begin
          pend_valid_d = pend_valid_q && !pend_move;
        end
      endcase
    end
  end

  always_comb begin
    sh_valid_d = sh_valid_q;
    sh_d       = sh_q;
    cnt_d      = cnt_q;
    total_d    = total_q;
    if (sh_done) begin
      sh_valid_d = pend_valid_q;
      sh_d       = pend_frame_q;
      cnt_d      = '0;
      total_d    = pend_two_q ? LastTwoWord : LastOneWord;
    end else if (out_acc) begin
      sh_d  = {sh_q[FrameBits-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q       <= 1'b0;
      first_q      <= 8'd0;
      second_q     <= 8'd0;
      pend_valid_q <= 1'b0;
      sh_valid_q   <= 1'b0;
      cnt_q        <= '0;
      total_q      <= LastOneWord;
    end else begin
      if (in_acc) begin
        slot_q   <= slot_d;
        first_q  <= first_d;
        second_q <= second_d;
      end
      pend_valid_q <= pend_valid_d;
      sh_valid_q   <= sh_valid_d;
      cnt_q        <= cnt_d;
      total_q      <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_frame_q <= pend_frame_d;
    pend_two_q   <= pend_two_d;
    sh_q         <= sh_d;
  end

  a_stall_needs_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> pend_valid_q)
    else $error("input stalled without a held frame");

  a_last_at_word_end : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_o |-> word_end_o)
    else $error("final bit not at a word boundary");

  a_pending_held : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q && !pend_move |=> pend_valid_q && $stable(pend_frame_q))
    else $error("held frame lost or changed");

  a_no_frame_in_mode_none : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && mode_q == MODE_NONE && !pend_valid_q |=> !pend_valid_q)
    else $error("frame built with channel mode none");

  a_count_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cnt_q <= total_q)
    else $error("bit counter passed the frame length");

endmodule

`default_nettype wire
